// ===== rtl/odo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_pkg
// shared constants, types and the cordic arctangent table for the odometry
// ----------------------------------------------------------------------------
package odo_pkg;

   localparam int CordicSteps = 24;
   localparam int CordicRuns  = (CordicSteps > 32) ? 32 : CordicSteps;

   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_TRAVEL = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_AXLE   = 2'd1;

   localparam logic [23:0] TravelReset = 24'd101024;
   localparam logic [23:0] AxleReset   = 24'd104858;
   localparam logic [25:0] GainInvQ22  = 26'd2547003;
   localparam logic [29:0] TurnPerRad  = 30'd683565276;

   localparam int MulAWidth = 33;
   localparam int MulBWidth = 31;
   localparam int ProdWidth = 64;
   localparam int TrigWidth = 27;

   typedef struct packed {
      logic                        done;
      logic signed [TrigWidth-1:0] cos_val;
      logic signed [TrigWidth-1:0] sin_val;
   } cordic_res_type;

   function automatic logic [29:0] atan_angle(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/odo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module odo_mul (
   input  logic                                  clock,
   input  logic signed [odo_pkg::MulAWidth-1:0]  mul_a,
   input  logic signed [odo_pkg::MulBWidth-1:0]  mul_b,
   output logic signed [odo_pkg::ProdWidth-1:0]  prod
);
   import odo_pkg::*;

   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [ProdWidth-1:0] prod_in;

   assign prod_in = ProdWidth'(mul_a) * ProdWidth'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/odo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module odo_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             angle,
   output odo_pkg::cordic_res_type res
);
   import odo_pkg::*;

   logic signed [25:0] x_ff, x_in;
   logic signed [25:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               flip_ff, flip_in;

   logic        flip_now;
   logic [31:0] ang_adj;
   logic [4:0]  idx;
   logic signed [25:0] ddx, ddy;
   logic signed [33:0] step_ang;

   assign flip_now = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
   assign ang_adj  = flip_now ? (angle + 32'h8000_0000) : angle;
   assign idx      = cnt_ff[4:0];
   assign ddx      = y_ff >>> idx;
   assign ddy      = x_ff >>> idx;
   assign step_ang = $signed({4'd0, atan_angle(idx)});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      flip_in = flip_ff;
      if (start) begin
         x_in    = $signed(GainInvQ22);
         y_in    = '0;
         z_in    = 34'($signed(ang_adj));
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
         flip_in = flip_now;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - ddx;
            y_in = y_ff + ddy;
            z_in = z_ff - step_ang;
         end else begin
            x_in = x_ff + ddx;
            y_in = y_ff - ddy;
            z_in = z_ff + step_ang;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(CordicRuns - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign res.done    = done_ff;
   assign res.cos_val = flip_ff ? -TrigWidth'(x_ff) : TrigWidth'(x_ff);
   assign res.sin_val = flip_ff ? -TrigWidth'(y_ff) : TrigWidth'(y_ff);

endmodule

// ===== rtl/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// dead-reckoning pose integrator for a two-wheel differential drive
// ----------------------------------------------------------------------------
// Each tick, from the req transfer to rsp valid, is paced by
// the iterative cordic (one micro-rotation per cycle, 24 of them) that turns
// the old heading into cosine and sine; the velocity, distance and heading
// products run meanwhile on one shared 33x31 multiplier, and the four
// position products follow once the cordic is done. A new tick is taken only
// when the block is idle; a finished result waits in the rsp register.
// Config writes are accepted at any time (csr_ready is tied high) and should
// only be issued while idle.
module differential_drive_odometry (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [15:0]                   req_left_speed,
   input  logic signed [15:0]                   req_right_speed,
   input  logic [23:0]                          req_elapsed_time,
   // pose output channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_pos_x,
   output logic signed [31:0]                   rsp_pos_y,
   output logic [31:0]                          rsp_heading,
   output logic signed [31:0]                   rsp_linear_velocity,
   output logic signed [31:0]                   rsp_angular_velocity,
   // config write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [odo_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [23:0]                          csr_data
);
   import odo_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_DIFF, S_OMEGA, S_DIST, S_DTH, S_MAG, S_TLO, S_THI,
      S_TURN, S_CWAIT, S_XHI, S_XADD, S_YHI, S_YADD, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [23:0] travel_ff, travel_in;
   logic [23:0] axle_ff, axle_in;

   // pose state
   logic [31:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] head_ff, head_in;

   // latched tick and intermediate values
   logic signed [15:0] ls_ff, ls_in;
   logic signed [15:0] rs_ff, rs_in;
   logic [23:0]        dt_ff, dt_in;
   logic signed [31:0] mean_ff, mean_in;
   logic signed [31:0] omega_ff, omega_in;
   logic signed [39:0] dist_ff, dist_in;
   logic               neg_ff, neg_in;
   logic [55:0]        mag_ff, mag_in;
   logic [31:0]        tlo_ff, tlo_in;
   logic signed [63:0] plo_ff, plo_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in;
   logic signed [31:0] rsp_y_ff, rsp_y_in;
   logic [31:0]        rsp_h_ff, rsp_h_in;
   logic signed [31:0] rsp_lin_ff, rsp_lin_in;
   logic signed [31:0] rsp_ang_ff, rsp_ang_in;

   // shared multiplier and cordic
   logic signed [MulAWidth-1:0] mul_a;
   logic signed [MulBWidth-1:0] mul_b;
   logic signed [ProdWidth-1:0] prod;
   cordic_res_type              trig;
   logic                        req_xfer;

   logic signed [16:0] spd_sum, spd_diff;
   logic signed [MulBWidth-1:0] travel_b, axle_b, dt_b, turn_b;
   logic signed [MulAWidth-1:0] dist_lo_a, dist_hi_a;
   logic               omega_fits;
   logic signed [63:0] pos_sum;
   logic [63:0]        prod_abs;
   logic [31:0]        turn_mag;

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign spd_sum   = 17'(ls_ff) + 17'(rs_ff);
   assign spd_diff  = 17'(ls_ff) - 17'(rs_ff);
   assign travel_b  = $signed({7'd0, travel_ff});
   assign axle_b    = $signed({7'd0, axle_ff});
   assign dt_b      = $signed({7'd0, dt_ff});
   assign turn_b    = $signed({1'b0, TurnPerRad});
   assign dist_lo_a = $signed({13'd0, dist_ff[19:0]});
   assign dist_hi_a = MulAWidth'($signed(dist_ff[39:20]));

   // product sign bits above the q16.16 range must all agree to fit
   assign omega_fits = (&prod[63:47]) || !(|prod[63:47]);
   assign pos_sum    = (prod <<< 20) + plo_ff;
   assign prod_abs   = prod[63] ? (64'd0 - prod) : prod;
   assign turn_mag   = prod[31:0] + tlo_ff;

   odo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // cordic starts on the tick transfer with the heading from before the tick
   odo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (req_xfer),
      .angle (head_ff),
      .res   (trig)
   );

   // multiplier operand select, odo_mul registers the product
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SUM: begin
            mul_a = MulAWidth'(spd_sum);
            mul_b = travel_b;
         end
         S_DIFF: begin
            mul_a = MulAWidth'(spd_diff);
            mul_b = travel_b;
         end
         S_OMEGA: begin
            mul_a = prod[40:8];
            mul_b = axle_b;
         end
         S_DIST: begin
            mul_a = MulAWidth'(mean_ff);
            mul_b = dt_b;
         end
         S_DTH: begin
            mul_a = MulAWidth'(omega_ff);
            mul_b = dt_b;
         end
         S_TLO: begin
            mul_a = $signed({1'b0, mag_ff[31:0]});
            mul_b = turn_b;
         end
         S_THI: begin
            mul_a = $signed({9'd0, mag_ff[55:32]});
            mul_b = turn_b;
         end
         S_CWAIT: begin
            mul_a = dist_lo_a;
            mul_b = MulBWidth'(trig.cos_val);
         end
         S_XHI: begin
            mul_a = dist_hi_a;
            mul_b = MulBWidth'(trig.cos_val);
         end
         S_XADD: begin
            mul_a = dist_lo_a;
            mul_b = MulBWidth'(trig.sin_val);
         end
         S_YHI: begin
            mul_a = dist_hi_a;
            mul_b = MulBWidth'(trig.sin_val);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      travel_in    = travel_ff;
      axle_in      = axle_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      head_in      = head_ff;
      ls_in        = ls_ff;
      rs_in        = rs_ff;
      dt_in        = dt_ff;
      mean_in      = mean_ff;
      omega_in     = omega_ff;
      dist_in      = dist_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      tlo_in       = tlo_ff;
      plo_in       = plo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;

      // config write, unknown indexes dropped
      if (csr_valid) begin
         if (csr_index == CSR_TRAVEL) begin
            travel_in = csr_data;
         end else if (csr_index == CSR_AXLE) begin
            axle_in = csr_data;
         end
      end

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ls_in    = req_left_speed;
               rs_in    = req_right_speed;
               dt_in    = req_elapsed_time;
               state_in = S_SUM;
            end
         end
         S_SUM:   state_in = S_DIFF;
         S_DIFF: begin
            // mean wheel velocity, q16.16
            mean_in  = prod[40:9];
            state_in = S_OMEGA;
         end
         S_OMEGA: state_in = S_DIST;
         S_DIST: begin
            // turn rate, saturated to q16.16
            if (omega_fits) begin
               omega_in = prod[47:16];
            end else if (prod[63]) begin
               omega_in = 32'sh8000_0000;
            end else begin
               omega_in = 32'sh7fff_ffff;
            end
            state_in = S_DTH;
         end
         S_DTH: begin
            // distance this tick, q.16
            dist_in  = prod[55:16];
            state_in = S_MAG;
         end
         S_MAG: begin
            // heading change in q.32 rad, split into sign and magnitude
            neg_in   = prod[63];
            mag_in   = prod_abs[55:0];
            state_in = S_TLO;
         end
         S_TLO:   state_in = S_THI;
         S_THI: begin
            tlo_in   = prod[63:32];
            state_in = S_TURN;
         end
         S_TURN: begin
            // radians to binary angle, truncated toward zero
            head_in  = neg_ff ? (head_ff - turn_mag) : (head_ff + turn_mag);
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (trig.done) begin
               state_in = S_XHI;
            end
         end
         S_XHI: begin
            plo_in   = prod;
            state_in = S_XADD;
         end
         S_XADD: begin
            x_in     = x_ff + pos_sum[53:22];
            state_in = S_YHI;
         end
         S_YHI: begin
            plo_in   = prod;
            state_in = S_YADD;
         end
         S_YADD: begin
            y_in     = y_ff + pos_sum[53:22];
            state_in = S_OUT;
         end
         S_OUT: begin
            // load once the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_h_in     = head_ff;
               rsp_lin_in   = mean_ff;
               rsp_ang_in   = omega_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         travel_ff    <= TravelReset;
         axle_ff      <= AxleReset;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         travel_ff    <= travel_in;
         axle_ff      <= axle_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ls_ff      <= ls_in;
      rs_ff      <= rs_in;
      dt_ff      <= dt_in;
      mean_ff    <= mean_in;
      omega_ff   <= omega_in;
      dist_ff    <= dist_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      tlo_ff     <= tlo_in;
      plo_ff     <= plo_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_lin_ff <= rsp_lin_in;
      rsp_ang_ff <= rsp_ang_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pos_x            = rsp_x_ff;
   assign rsp_pos_y            = rsp_y_ff;
   assign rsp_heading          = rsp_h_ff;
   assign rsp_linear_velocity  = rsp_lin_ff;
   assign rsp_angular_velocity = rsp_ang_ff;

endmodule
